// File: design/sifp_pkg.sv
// sifp_pkg: shared constants, types and csr codes for the symbolic ilu(k) fill pattern block
// no dependencies; imported by every module of the block
package sifp_pkg;

   localparam int MAX_N         = 4096;
   localparam int MAX_ROW_LEN   = 64;
   localparam int U_STORE_DEPTH = 16384;
   localparam int LEVEL_WIDTH   = 8;

   localparam int COL_W   = $clog2(MAX_N);
   localparam int IDX_W   = $clog2(MAX_N + 1);
   localparam int CNT_W   = $clog2(MAX_ROW_LEN + 2);
   localparam int OBUF_DEPTH = MAX_ROW_LEN + 1;
   localparam int UADDR_W = $clog2(U_STORE_DEPTH);
   localparam int UFILL_W = $clog2(U_STORE_DEPTH + 2);
   localparam int ENT_W   = COL_W + LEVEL_WIDTH;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

   localparam int NUM_ROWS_W = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FILL = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_TDATA_W = ((COL_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * COL_W + LEVEL_WIDTH + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 3;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             use_col;
      logic             last;
   } sifp_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]       n;
      logic [LEVEL_WIDTH-1:0] lf;
      logic                   restart;
   } sifp_cfg_type;

endpackage

// File: design/sifp_front.sv
// sifp_front: csr registers and input classification (range check on column)
// depends on sifp_pkg; feeds sifp_queue and hands the configuration to sifp_back
module sifp_front import sifp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   q_full,
   output logic                   q_push,
   output sifp_item_type          q_item,
   output sifp_cfg_type           cfg
);

   logic [IDX_W-1:0]       n_ff, n_in;
   logic [LEVEL_WIDTH-1:0] lf_ff, lf_in;
   logic [NUM_ROWS_W-1:0]  nr_val;
   logic [LEVEL_WIDTH-1:0] lf_val;
   logic                   in_range;

   assign nr_val = csr_wdata[NUM_ROWS_W-1:0];
   assign lf_val = csr_wdata[LEVEL_WIDTH-1:0];

   always_comb begin
      n_in  = n_ff;
      lf_in = lf_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NUM_ROWS: begin
               if (nr_val == '0) begin
                  n_in = IDX_W'(1);
               end else if (nr_val > NUM_ROWS_W'(MAX_N)) begin
                  n_in = IDX_W'(MAX_N);
               end else begin
                  n_in = IDX_W'(nr_val);
               end
            end
            CSR_MAX_FILL: begin
               // infinite level is never kept
               lf_in = (lf_val > LEVEL_MAX - 1'b1) ? LEVEL_MAX - 1'b1 : lf_val;
            end
            default: begin
               n_in = n_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff  <= IDX_W'(MAX_N);
         lf_ff <= '0;
      end else begin
         n_ff  <= n_in;
         lf_ff <= lf_in;
      end
   end

   assign in_range = {1'b0, req_tdata[COL_W-1:0]} < n_ff;

   // out-of-range entries are dropped here, row ends always pass
   assign req_tready     = !q_full;
   assign q_push         = req_tvalid && !q_full && (in_range || req_tlast);
   assign q_item.col     = req_tdata[COL_W-1:0];
   assign q_item.use_col = in_range;
   assign q_item.last    = req_tlast;

   assign cfg.n       = n_ff;
   assign cfg.lf      = lf_ff;
   assign cfg.restart = csr_we && (csr_addr == CSR_NUM_ROWS);

endmodule

// File: design/sifp_queue.sv
// sifp_queue: short fifo of classified items between front and back
// depends on sifp_pkg for the item type and depth
module sifp_queue import sifp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sifp_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          q_valid,
   output sifp_item_type q_item
);

   sifp_item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_pop;

   assign full    = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_item  = slot_ff[rd_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: design/sifp_back.sv
// sifp_back: row builder, fill merge over stored upper rows, gather and emit sequencer
// depends on sifp_pkg; takes items from sifp_queue, drives the result register
module sifp_back import sifp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  sifp_cfg_type           cfg,
   input  logic                   q_valid,
   input  sifp_item_type          q_item,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic                   rsp_tlast
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_ITEM  = 5'd1;
   localparam logic [4:0] S_WALK  = 5'd2;
   localparam logic [4:0] S_WALK2 = 5'd3;
   localparam logic [4:0] S_MSTART= 5'd4;
   localparam logic [4:0] S_ROW   = 5'd5;
   localparam logic [4:0] S_ROW2  = 5'd6;
   localparam logic [4:0] S_ROW3  = 5'd7;
   localparam logic [4:0] S_UREAD = 5'd8;
   localparam logic [4:0] S_UDATA = 5'd9;
   localparam logic [4:0] S_MINS  = 5'd10;
   localparam logic [4:0] S_ADV   = 5'd11;
   localparam logic [4:0] S_NEXTR = 5'd12;
   localparam logic [4:0] S_GSTART= 5'd13;
   localparam logic [4:0] S_GLO   = 5'd14;
   localparam logic [4:0] S_GLO2  = 5'd15;
   localparam logic [4:0] S_GUP   = 5'd16;
   localparam logic [4:0] S_GUP2  = 5'd17;
   localparam logic [4:0] S_GFIX  = 5'd18;
   localparam logic [4:0] S_EMIT  = 5'd19;
   localparam logic [4:0] S_EOUT  = 5'd20;
   localparam logic [4:0] S_FIN   = 5'd21;

   localparam logic [CNT_W-1:0]   ROW_LEN = CNT_W'(MAX_ROW_LEN);
   localparam logic [UFILL_W-1:0] U_DEPTH = UFILL_W'(U_STORE_DEPTH);

   logic [4:0]             state_ff, state_in;
   logic [COL_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       raw_ff, raw_in;
   logic                   trunc_ff, trunc_in;
   logic [COL_W-1:0]       row_ff, row_in;
   logic [UFILL_W-1:0]     fill_ff, fill_in;
   logic [COL_W-1:0]       prev_ff, prev_in;
   logic [IDX_W-1:0]       nxt_ff, nxt_in;
   logic [IDX_W-1:0]       r_ff, r_in;
   logic [LEVEL_WIDTH-1:0] levr_ff, levr_in;
   logic [UFILL_W-1:0]     ii_ff, ii_in;
   logic [UFILL_W-1:0]     e_ff, e_in;
   logic [COL_W-1:0]       ins_ff, ins_in;
   sifp_item_type          item_ff, item_in;
   logic [CNT_W-1:0]       m_ff, m_in;
   logic [CNT_W-1:0]       diag_ff, diag_in;
   logic                   added_ff, added_in;
   logic [IDX_W-1:0]       gnext_ff, gnext_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [ENT_W-1:0]       lent_ff, lent_in;

   logic                   rv_ff, rv_in;
   logic [COL_W-1:0]       rrow_ff, rrow_in;
   logic [COL_W-1:0]       rcol_ff, rcol_in;
   logic [LEVEL_WIDTH-1:0] rlev_ff, rlev_in;
   logic                   rdiag_ff, rdiag_in;
   logic                   rend_ff, rend_in;
   logic                   radd_ff, radd_in;
   logic                   rtrunc_ff, rtrunc_in;

   // working memories
   logic [IDX_W-1:0]       link_mem  [MAX_N];
   logic [LEVEL_WIDTH-1:0] lev_mem   [MAX_N];
   logic [UFILL_W-1:0]     start_mem [MAX_N + 1];
   logic [ENT_W-1:0]       upper_mem [U_STORE_DEPTH];
   logic [ENT_W-1:0]       obuf_mem  [OBUF_DEPTH];

   logic                   ll_re;
   logic [COL_W-1:0]       ll_ra;
   logic                   link_we, lev_we, st_re, st_we, up_re, up_we, ob_re, ob_we;
   logic [COL_W-1:0]       link_wa, lev_wa;
   logic [IDX_W-1:0]       link_wd;
   logic [LEVEL_WIDTH-1:0] lev_wd;
   logic [IDX_W-1:0]       st_ra, st_wa;
   logic [UFILL_W-1:0]     st_wd;
   logic [UADDR_W-1:0]     up_ra, up_wa;
   logic [ENT_W-1:0]       up_wd, ob_wd;
   logic [CNT_W-1:0]       ob_ra, ob_wa;

   logic [IDX_W-1:0]       link_rd_ff;
   logic [LEVEL_WIDTH-1:0] lev_rd_ff;
   logic [UFILL_W-1:0]     st_rd_ff;
   logic [ENT_W-1:0]       up_rd_ff;
   logic [ENT_W-1:0]       ob_rd_ff;

   logic [COL_W-1:0]       u_col, o_col;
   logic [LEVEL_WIDTH-1:0] u_lev, o_lev, nl;
   logic [LEVEL_WIDTH+1:0] nl_sum;
   logic [IDX_W-1:0]       row_ext, row_next, c_ext;
   logic [CNT_W-1:0]       k_next;
   logic                   out_free;

   assign u_col    = up_rd_ff[ENT_W-1 -: COL_W];
   assign u_lev    = up_rd_ff[LEVEL_WIDTH-1:0];
   assign o_col    = ob_rd_ff[ENT_W-1 -: COL_W];
   assign o_lev    = ob_rd_ff[LEVEL_WIDTH-1:0];
   assign nl_sum   = {2'b00, levr_ff} + {2'b00, u_lev} + 1'b1;
   assign nl       = (nl_sum > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : nl_sum[LEVEL_WIDTH-1:0];
   assign row_ext  = {1'b0, row_ff};
   assign row_next = row_ext + 1'b1;
   assign c_ext    = {1'b0, u_col};
   assign k_next   = k_ff + 1'b1;
   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      raw_in   = raw_ff;
      trunc_in = trunc_ff;
      row_in   = row_ff;
      fill_in  = fill_ff;
      prev_in  = prev_ff;
      nxt_in   = nxt_ff;
      r_in     = r_ff;
      levr_in  = levr_ff;
      ii_in    = ii_ff;
      e_in     = e_ff;
      ins_in   = ins_ff;
      item_in  = item_ff;
      m_in     = m_ff;
      diag_in  = diag_ff;
      added_in = added_ff;
      gnext_in = gnext_ff;
      k_in     = k_ff;
      lent_in  = lent_ff;
      rv_in    = rv_ff && !rsp_tready;
      rrow_in  = rrow_ff;
      rcol_in  = rcol_ff;
      rlev_in  = rlev_ff;
      rdiag_in = rdiag_ff;
      rend_in  = rend_ff;
      radd_in  = radd_ff;
      rtrunc_in = rtrunc_ff;

      q_pop   = 1'b0;
      ll_re   = 1'b0;
      ll_ra   = '0;
      link_we = 1'b0;
      link_wa = '0;
      link_wd = '0;
      lev_we  = 1'b0;
      lev_wa  = '0;
      lev_wd  = '0;
      st_re   = 1'b0;
      st_ra   = '0;
      st_we   = 1'b0;
      st_wa   = row_next;
      st_wd   = fill_ff;
      up_re   = 1'b0;
      up_ra   = ii_ff[UADDR_W-1:0];
      up_we   = 1'b0;
      up_wa   = fill_ff[UADDR_W-1:0];
      up_wd   = ob_rd_ff;
      ob_re   = 1'b0;
      ob_ra   = k_ff;
      ob_we   = 1'b0;
      ob_wa   = m_ff;
      ob_wd   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_ITEM;
            end
         end
         // insert one column into the sorted list, duplicates fall out
         S_ITEM: begin
            state_in = item_ff.last ? S_MSTART : S_IDLE;
            ins_in   = item_ff.col;
            if (item_ff.use_col) begin
               if (raw_ff < ROW_LEN) begin
                  raw_in = raw_ff + 1'b1;
                  if (cnt_ff == '0 || item_ff.col < head_ff) begin
                     link_we = 1'b1;
                     link_wa = item_ff.col;
                     link_wd = (cnt_ff == '0) ? cfg.n : {1'b0, head_ff};
                     lev_we  = 1'b1;
                     lev_wa  = item_ff.col;
                     head_in = item_ff.col;
                     cnt_in  = cnt_ff + 1'b1;
                  end else if (item_ff.col != head_ff) begin
                     prev_in  = head_ff;
                     ll_re    = 1'b1;
                     ll_ra    = head_ff;
                     state_in = S_WALK;
                  end
               end else begin
                  trunc_in = 1'b1;
               end
            end
         end
         S_WALK: begin
            if ({1'b0, ins_ff} == link_rd_ff) begin
               state_in = item_ff.last ? S_MSTART : S_IDLE;
            end else if ({1'b0, ins_ff} < link_rd_ff) begin
               link_we  = 1'b1;
               link_wa  = prev_ff;
               link_wd  = {1'b0, ins_ff};
               lev_we   = 1'b1;
               lev_wa   = ins_ff;
               nxt_in   = link_rd_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WALK2;
            end else begin
               prev_in = link_rd_ff[COL_W-1:0];
               ll_re   = 1'b1;
               ll_ra   = link_rd_ff[COL_W-1:0];
            end
         end
         S_WALK2: begin
            link_we  = 1'b1;
            link_wa  = ins_ff;
            link_wd  = nxt_ff;
            state_in = item_ff.last ? S_MSTART : S_IDLE;
         end
         S_MSTART: begin
            r_in     = (cnt_ff == '0) ? cfg.n : {1'b0, head_ff};
            state_in = S_ROW;
         end
         // walk the lower entries and merge their stored upper rows
         S_ROW: begin
            if (r_ff < row_ext) begin
               ll_re    = 1'b1;
               ll_ra    = r_ff[COL_W-1:0];
               st_re    = 1'b1;
               st_ra    = r_ff;
               state_in = S_ROW2;
            end else begin
               state_in = S_GSTART;
            end
         end
         S_ROW2: begin
            nxt_in   = link_rd_ff;
            levr_in  = lev_rd_ff;
            prev_in  = r_ff[COL_W-1:0];
            ii_in    = st_rd_ff + 1'b1;
            st_re    = 1'b1;
            st_ra    = r_ff + 1'b1;
            state_in = S_ROW3;
         end
         S_ROW3: begin
            e_in     = st_rd_ff;
            state_in = S_UREAD;
         end
         S_UREAD: begin
            if (ii_ff < e_ff && ii_ff < U_DEPTH) begin
               up_re    = 1'b1;
               state_in = S_UDATA;
            end else begin
               ll_re    = 1'b1;
               ll_ra    = r_ff[COL_W-1:0];
               state_in = S_NEXTR;
            end
         end
         S_NEXTR: begin
            r_in     = link_rd_ff;
            state_in = S_ROW;
         end
         S_UDATA: begin
            if (c_ext < nxt_ff) begin
               state_in = S_UREAD;
               ii_in    = ii_ff + 1'b1;
               if (c_ext < cfg.n && nl <= cfg.lf) begin
                  if (cnt_ff < ROW_LEN) begin
                     link_we  = 1'b1;
                     link_wa  = prev_ff;
                     link_wd  = c_ext;
                     lev_we   = 1'b1;
                     lev_wa   = u_col;
                     lev_wd   = nl;
                     ins_in   = u_col;
                     ii_in    = ii_ff;
                     state_in = S_MINS;
                  end else begin
                     trunc_in = 1'b1;
                  end
               end
            end else if (nxt_ff >= cfg.n) begin
               ll_re    = 1'b1;
               ll_ra    = r_ff[COL_W-1:0];
               state_in = S_NEXTR;
            end else begin
               prev_in  = nxt_ff[COL_W-1:0];
               ll_re    = 1'b1;
               ll_ra    = nxt_ff[COL_W-1:0];
               state_in = S_ADV;
            end
         end
         S_MINS: begin
            link_we  = 1'b1;
            link_wa  = ins_ff;
            link_wd  = nxt_ff;
            prev_in  = ins_ff;
            cnt_in   = cnt_ff + 1'b1;
            ii_in    = ii_ff + 1'b1;
            state_in = S_UREAD;
         end
         S_ADV: begin
            nxt_in = link_rd_ff;
            if (u_col == prev_ff) begin
               // existing entry keeps the smaller level
               if (nl < lev_rd_ff) begin
                  lev_we = 1'b1;
                  lev_wa = u_col;
                  lev_wd = nl;
               end
               ii_in    = ii_ff + 1'b1;
               state_in = S_UREAD;
            end else begin
               state_in = S_UDATA;
            end
         end
         S_GSTART: begin
            gnext_in = (cnt_ff == '0) ? cfg.n : {1'b0, head_ff};
            m_in     = '0;
            state_in = S_GLO;
         end
         S_GLO: begin
            if (gnext_ff < row_ext && m_ff < ROW_LEN) begin
               ll_re    = 1'b1;
               ll_ra    = gnext_ff[COL_W-1:0];
               state_in = S_GLO2;
            end else begin
               added_in = gnext_ff != row_ext;
               diag_in  = m_ff;
               if (gnext_ff != row_ext) begin
                  ob_we   = 1'b1;
                  ob_wd   = {row_ff, LEVEL_MAX};
                  lent_in = {row_ff, LEVEL_MAX};
                  m_in    = m_ff + 1'b1;
               end
               state_in = S_GUP;
            end
         end
         S_GLO2: begin
            ob_we    = 1'b1;
            ob_wd    = {gnext_ff[COL_W-1:0], lev_rd_ff};
            lent_in  = {gnext_ff[COL_W-1:0], lev_rd_ff};
            m_in     = m_ff + 1'b1;
            gnext_in = link_rd_ff;
            state_in = S_GLO;
         end
         S_GUP: begin
            if (gnext_ff < cfg.n && m_ff <= ROW_LEN) begin
               ll_re    = 1'b1;
               ll_ra    = gnext_ff[COL_W-1:0];
               state_in = S_GUP2;
            end else begin
               state_in = S_GFIX;
            end
         end
         S_GUP2: begin
            ob_we    = 1'b1;
            ob_wd    = {gnext_ff[COL_W-1:0], lev_rd_ff};
            lent_in  = {gnext_ff[COL_W-1:0], lev_rd_ff};
            m_in     = m_ff + 1'b1;
            gnext_in = link_rd_ff;
            state_in = S_GUP;
         end
         // row one over the limit: drop the largest non-diagonal column
         S_GFIX: begin
            if (m_ff > ROW_LEN) begin
               if (diag_ff == m_ff - 1'b1) begin
                  ob_we   = 1'b1;
                  ob_wa   = m_ff - 2'd2;
                  ob_wd   = lent_ff;
                  diag_in = m_ff - 2'd2;
               end
               m_in     = m_ff - 1'b1;
               trunc_in = 1'b1;
            end
            k_in     = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            ob_re    = 1'b1;
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (out_free) begin
               rv_in     = 1'b1;
               rrow_in   = row_ff;
               rcol_in   = o_col;
               rlev_in   = o_lev;
               rdiag_in  = k_ff == diag_ff;
               rend_in   = k_next == m_ff;
               radd_in   = added_ff;
               rtrunc_in = trunc_ff;
               if (k_ff >= diag_ff && fill_ff < U_DEPTH) begin
                  up_we   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               k_in     = k_next;
               state_in = (k_next == m_ff) ? S_FIN : S_EMIT;
            end
         end
         S_FIN: begin
            st_we    = 1'b1;
            raw_in   = '0;
            cnt_in   = '0;
            trunc_in = 1'b0;
            state_in = S_IDLE;
            if (row_next >= cfg.n) begin
               row_in  = '0;
               fill_in = '0;
            end else begin
               row_in = row_next[COL_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg.restart) begin
         raw_in   = '0;
         cnt_in   = '0;
         trunc_in = 1'b0;
         row_in   = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         raw_ff   <= '0;
         trunc_ff <= 1'b0;
         row_ff   <= '0;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         raw_ff   <= raw_in;
         trunc_ff <= trunc_in;
         row_ff   <= row_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff   <= head_in;
      prev_ff   <= prev_in;
      nxt_ff    <= nxt_in;
      r_ff      <= r_in;
      levr_ff   <= levr_in;
      ii_ff     <= ii_in;
      e_ff      <= e_in;
      ins_ff    <= ins_in;
      item_ff   <= item_in;
      m_ff      <= m_in;
      diag_ff   <= diag_in;
      added_ff  <= added_in;
      gnext_ff  <= gnext_in;
      k_ff      <= k_in;
      lent_ff   <= lent_in;
      rrow_ff   <= rrow_in;
      rcol_ff   <= rcol_in;
      rlev_ff   <= rlev_in;
      rdiag_ff  <= rdiag_in;
      rend_ff   <= rend_in;
      radd_ff   <= radd_in;
      rtrunc_ff <= rtrunc_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (ll_re) begin
         link_rd_ff <= link_mem[ll_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (lev_we) begin
         lev_mem[lev_wa] <= lev_wd;
      end
      if (ll_re) begin
         lev_rd_ff <= lev_mem[ll_ra];
      end
   end

   // start of row zero is always zero
   always_ff @(posedge clock) begin
      if (st_we) begin
         start_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_rd_ff <= (st_ra == '0) ? '0 : start_mem[st_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (up_we) begin
         upper_mem[up_wa] <= up_wd;
      end
      if (up_re) begin
         up_rd_ff <= upper_mem[up_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ob_we) begin
         obuf_mem[ob_wa] <= ob_wd;
      end
      if (ob_re) begin
         ob_rd_ff <= obuf_mem[ob_ra];
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rlev_ff, rcol_ff, rrow_ff});
   assign rsp_tuser  = {rtrunc_ff, radd_ff, rdiag_ff};
   assign rsp_tlast  = rend_ff;

endmodule

// File: design/symbolic_ilu_fill_pattern.sv
// symbolic_ilu_fill_pattern: top level of the ilu(k) level-of-fill pattern generator
// depends on sifp_pkg, sifp_front, sifp_queue, sifp_back
//
//   group  dir  handshake          payload
//   req_   in   tvalid/tready      tdata[11:0] column, tlast last_in_row
//   rsp_   out  tvalid/tready      tdata row_number, out_column, fill_level; tuser flags;
//                                  tlast end_of_row
//   csr_   in   we (no wait)       addr 0 num_rows, addr 1 max_fill_level
//
// an entry that becomes the head of the list is linked in directly, otherwise the sorted
// list is walked with one link memory read per element walked past; a row end then merges
// the stored upper rows of its lower entries, gathers the row into the output buffer and
// emits the results
// reset is synchronous; no memory clearing pass, row zero start is forced to zero
// the four-entry queue keeps accepting items until it is full while the back end merges or the result stalls
module symbolic_ilu_fill_pattern import sifp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [11:0] column
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [11:0] row_number, [23:12] out_column,
                                               // [31:24] fill_level
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // [0] is_diagonal, [1] diagonal_added,
                                               // [2] row_truncated
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   sifp_item_type push_item, pop_item;
   sifp_cfg_type  cfg;
   logic          q_full, q_push, q_pop, q_valid;

   sifp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item),
      .cfg        (cfg)
   );

   sifp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_item    (pop_item)
   );

   sifp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/sifp_checker.sv
// sifp_checker: port-level assertions for symbolic_ilu_fill_pattern, bound to the top level
// depends on sifp_pkg
module sifp_checker import sifp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   // a stalled item stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // infinite level only on an inserted diagonal
   a_inf_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2*COL_W +: LEVEL_WIDTH] == LEVEL_MAX |->
         rsp_tuser[0] && rsp_tuser[1])
      else $error("infinite level off the inserted diagonal");

   a_diag_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[COL_W +: COL_W] == rsp_tdata[COL_W-1:0])
      else $error("diagonal column differs from row");

endmodule

bind symbolic_ilu_fill_pattern sifp_checker u_sifp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
